// ----- hw/rtl/quaternion_to_euler_angles_core_macros.svh -----
// Assertion macros shared by the quaternion to Euler angle RTL.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define Q2E_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/q2e_pkg.sv -----
// Shared constants, types and the arctangent table of the quaternion to Euler angle core.
`default_nettype none
package q2e_pkg;

  localparam int IN_W    = 16;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;
  localparam int YAW_W   = 16;

  localparam int IN_FRAC_BITS_DEF  = 14;
  localparam int OUT_FRAC_BITS_DEF = 7;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam int ANG_FRAC  = 24;
  localparam int MAX_STEPS = 32;

  // Normalised operand width: magnitudes sit in [2^56, 2^57).
  localparam int NORM_W     = 58;
  localparam int LSH_STAGES = 6;
  localparam int NORM_LAT   = LSH_STAGES + 1;

  // Rotator datapath and angle accumulator widths.
  localparam int CW = 60;
  localparam int ZW = 34;

  // Pitch sine in Q30 and the integer square root datapath.
  localparam int SW         = 32;
  localparam int SQ_W       = 62;
  localparam int SQRT_TOP   = 60;
  localparam int SQRT_STEPS = SQRT_TOP / 2 + 1;

  // atan(2^-i) in degrees, scaled by 2^ANG_FRAC, rounded.
  localparam int unsigned ATAN_DEG_TAB [MAX_STEPS] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_vec_t;

  typedef struct packed {
    logic        [SQ_W-1:0] rem;
    logic        [SQ_W-1:0] root;
    logic signed [SW-1:0]   s;
  } sqrt_vec_t;

endpackage
`default_nettype wire

// ----- hw/rtl/q2e_sqrt_cell.sv -----
// One restoring step of the pipelined integer square root.
`default_nettype none
module q2e_sqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  logic                  clk,
  input  q2e_pkg::sqrt_vec_t    cell_i,
  output q2e_pkg::sqrt_vec_t    cell_o
);
  import q2e_pkg::*;

  localparam logic [SQ_W-1:0] BIT_V = SQ_W'(1) << BIT_POS;

  sqrt_vec_t       cell_r;
  sqrt_vec_t       cell_nxt;
  logic [SQ_W-1:0] trial;

  assign trial = cell_i.root + BIT_V;

  always_comb begin
    cell_nxt = cell_i;
    if (cell_i.rem >= trial) begin
      cell_nxt.rem  = cell_i.rem - trial;
      cell_nxt.root = (cell_i.root >> 1) + BIT_V;
    end else begin
      cell_nxt.root = cell_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

// ----- hw/rtl/q2e_cordic_cell.sv -----
// One vectoring micro-rotation of the arctangent chain.
`default_nettype none
module q2e_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  q2e_pkg::cordic_vec_t  cell_i,
  output q2e_pkg::cordic_vec_t  cell_o
);
  import q2e_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_DEG_TAB[STEP]);

  cordic_vec_t          cell_r;
  cordic_vec_t          cell_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign dx = cell_i.x >>> STEP;
  assign dy = cell_i.y >>> STEP;

  always_comb begin
    cell_nxt = cell_i;
    if (!cell_i.y[CW-1]) begin
      cell_nxt.x = cell_i.x + dy;
      cell_nxt.y = cell_i.y - dx;
      cell_nxt.z = cell_i.z + ANG;
    end else begin
      cell_nxt.x = cell_i.x - dy;
      cell_nxt.y = cell_i.y + dx;
      cell_nxt.z = cell_i.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

// ----- hw/rtl/q2e_norm.sv -----
// Staged joint power-of-two scaling of an arctangent operand pair.
`default_nettype none
module q2e_norm #(
  parameter int IW = 34
) (
  input  logic                              clk,
  input  logic signed [IW-1:0]              x_i,
  input  logic signed [IW-1:0]              y_i,
  output logic signed [q2e_pkg::NORM_W-1:0] x_o,
  output logic signed [q2e_pkg::NORM_W-1:0] y_o
);
  import q2e_pkg::*;

  localparam int EW  = (IW > NORM_W) ? IW : NORM_W;
  localparam int RSH = EW - NORM_W + 1;
  localparam logic signed [EW-1:0] LIM_P = EW'(1) << (NORM_W - 1);

  function automatic logic [NORM_W-2:0] mag(input logic signed [NORM_W-1:0] v);
    logic signed [NORM_W-1:0] a;
    a = v[NORM_W-1] ? -v : v;
    return a[NORM_W-2:0];
  endfunction

  logic signed [EW-1:0]     xe;
  logic signed [EW-1:0]     ye;
  logic signed [EW-1:0]     tx;
  logic signed [EW-1:0]     ty;
  logic signed [EW-1:0]     xs;
  logic signed [EW-1:0]     ys;
  logic signed [NORM_W-1:0] lx_r [LSH_STAGES+1];
  logic signed [NORM_W-1:0] ly_r [LSH_STAGES+1];
  logic        [NORM_W-2:0] m    [LSH_STAGES];

  // Floor shifts right, smallest count that brings both below 2^57.
  always_comb begin
    xe = EW'(x_i);
    ye = EW'(y_i);
    xs = xe >>> RSH;
    ys = ye >>> RSH;
    tx = xe;
    ty = ye;
    for (int n = RSH; n >= 0; n--) begin
      tx = xe >>> n;
      ty = ye >>> n;
      if (tx < LIM_P && tx > -LIM_P && ty < LIM_P && ty > -LIM_P) begin
        xs = tx;
        ys = ty;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < LSH_STAGES; g++) begin
      m[g] = mag(lx_r[g]) | mag(ly_r[g]);
    end
  end

  // Doublings in binary steps of 32, 16, 8, 4, 2 and 1 until the larger
  // magnitude reaches 2^56.
  always_ff @(posedge clk) begin
    lx_r[0] <= NORM_W'(xs);
    ly_r[0] <= NORM_W'(ys);
    for (int g = 0; g < LSH_STAGES; g++) begin
      if ((m[g] >> (NORM_W - 1 - (32 >> g))) == '0) begin
        lx_r[g+1] <= lx_r[g] <<< (32 >> g);
        ly_r[g+1] <= ly_r[g] <<< (32 >> g);
      end else begin
        lx_r[g+1] <= lx_r[g];
        ly_r[g+1] <= ly_r[g];
      end
    end
  end

  assign x_o = lx_r[LSH_STAGES];
  assign y_o = ly_r[LSH_STAGES];

endmodule
`default_nettype wire

// ----- hw/rtl/q2e_angle_lane.sv -----
// Scaling, quadrant fold, rotator chain and rounding for one atan2 angle.
`default_nettype none
module q2e_angle_lane #(
  parameter int IW            = 34,
  parameter int OW            = 16,
  parameter int CORDIC_STEPS  = q2e_pkg::CORDIC_STEPS_DEF,
  parameter int OUT_FRAC_BITS = q2e_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic signed [IW-1:0] x_i,
  input  logic signed [IW-1:0] y_i,
  output logic signed [OW-1:0] angle_o
);
  import q2e_pkg::*;

  localparam int SH = ANG_FRAC - OUT_FRAC_BITS;
  localparam logic signed [ZW-1:0] Z90    = ZW'(90 * (1 << ANG_FRAC));
  localparam logic signed [ZW-1:0] HALF   = ZW'(1) << (SH - 1);
  localparam logic signed [ZW-1:0] TOP_V  = (ZW'(1) << (OW - 1)) - ZW'(1);
  localparam logic signed [ZW-1:0] BOT_V  = -(ZW'(1) << (OW - 1));

  logic signed [NORM_W-1:0] nx;
  logic signed [NORM_W-1:0] ny;
  cordic_vec_t              pre_r;
  cordic_vec_t              pre_nxt;
  cordic_vec_t              chain [CORDIC_STEPS+1];
  logic signed [ZW-1:0]     zr;
  logic signed [ZW-1:0]     rnd;
  logic signed [OW-1:0]     angle_r;
  logic signed [OW-1:0]     angle_nxt;

  q2e_norm #(.IW(IW)) u_norm (
    .clk (clk),
    .x_i (x_i),
    .y_i (y_i),
    .x_o (nx),
    .y_o (ny)
  );

  // Fold the left half-plane onto the right with a quarter turn.
  always_comb begin
    pre_nxt.x    = CW'(nx);
    pre_nxt.y    = CW'(ny);
    pre_nxt.z    = '0;
    pre_nxt.zero = (nx == '0) && (ny == '0);
    if (nx[NORM_W-1]) begin
      if (!ny[NORM_W-1]) begin
        pre_nxt.x = CW'(ny);
        pre_nxt.y = -CW'(nx);
        pre_nxt.z = Z90;
      end else begin
        pre_nxt.x = -CW'(ny);
        pre_nxt.y = CW'(nx);
        pre_nxt.z = -Z90;
      end
    end
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
  end

  assign chain[0] = pre_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    q2e_cordic_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // Round half up, then saturate to the field.
  always_comb begin
    zr  = chain[CORDIC_STEPS].zero ? '0 : chain[CORDIC_STEPS].z;
    rnd = (zr + HALF) >>> SH;
    if (rnd > TOP_V) begin
      angle_nxt = OW'(TOP_V);
    end else if (rnd < BOT_V) begin
      angle_nxt = OW'(BOT_V);
    end else begin
      angle_nxt = OW'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign angle_o = angle_r;

endmodule
`default_nettype wire

// ----- hw/rtl/quaternion_to_euler_angles_core.sv -----
// Top level of the pipelined quaternion to roll, pitch and yaw converter.
//
//   Channel  | Ports                                   | Handshake
//   ---------+-----------------------------------------+------------------------------
//   input    | in_quat_w/x/y/z                         | start high, busy low
//   result   | out_roll/pitch/yaw_deg, out_pitch_clamped | out_strobe, one cycle
//
// A word is taken at every clock edge at which start is high and rst_n is high; busy is
// high only while rst_n is low, as the whole datapath is a pipeline with one word in
// each stage.
// Each word passes through the 31 square root cells of the pitch path and then
// through the normaliser, the rotator chain and the rounding stage.
// rst_n, sampled on clk, clears the valid pipe only; payload registers are not reset.
// The receiver cannot stall, so nothing ever holds the pipe.
`default_nettype none
module quaternion_to_euler_angles_core #(
  parameter int IN_FRAC_BITS  = q2e_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = q2e_pkg::OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS  = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_w,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_x,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_y,
  input  logic signed [q2e_pkg::IN_W-1:0]      in_quat_z,
  output logic                                 out_strobe,
  output logic signed [q2e_pkg::ROLL_W-1:0]    out_roll_deg,
  output logic signed [q2e_pkg::PITCH_W-1:0]   out_pitch_deg,
  output logic signed [q2e_pkg::YAW_W-1:0]     out_yaw_deg,
  output logic                                 out_pitch_clamped
);
  import q2e_pkg::*;

  // Products are in Q(2*IN_FRAC_BITS); the terms need room for the unit and two
  // doubled sums of 16-bit squares.
  localparam int K2     = 2 * IN_FRAC_BITS;
  localparam int TERM_W = ((K2 > 32) ? K2 : 32) + 2;
  localparam int PW     = 2 * IN_W;
  localparam int RSH_S  = (K2 > 30) ? K2 - 30 : 0;
  localparam int LSH_S  = (K2 < 30) ? 30 - K2 : 0;

  // The roll and yaw terms wait while the pitch path squares and takes the root.
  localparam int PRE_DLY   = 2 + SQRT_STEPS;
  localparam int LANE_LAT  = NORM_LAT + CORDIC_STEPS + 2;
  localparam int CLAMP_DLY = PRE_DLY + LANE_LAT;
  localparam int TOTAL     = 3 + PRE_DLY + LANE_LAT;

  localparam logic signed [TERM_W-1:0] ONE_T     = TERM_W'(1) << K2;
  localparam logic        [SQ_W-1:0]   SQRT_ONE  = SQ_W'(1) << SQRT_TOP;
  localparam int PITCH_LIM = (90 << OUT_FRAC_BITS) + 4;
  localparam int PITCH_MIN = ((90 << OUT_FRAC_BITS) - 4 < (1 << (PITCH_W - 1)) - 1) ?
                             (90 << OUT_FRAC_BITS) - 4 : (1 << (PITCH_W - 1)) - 1;

  logic accept;

  logic [TOTAL-1:0] vld_r;

  logic signed [IN_W-1:0] qw_r;
  logic signed [IN_W-1:0] qx_r;
  logic signed [IN_W-1:0] qy_r;
  logic signed [IN_W-1:0] qz_r;

  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  logic signed [TERM_W-1:0] sinr_nxt, cosr_nxt, siny_nxt, cosy_nxt;
  logic signed [TERM_W-1:0] s_raw, s_cl, s_sc;
  logic signed [SW-1:0]     s_nxt;
  logic                     clamp_nxt;

  logic signed [TERM_W-1:0] sinr_r, cosr_r, siny_r, cosy_r;
  logic signed [SW-1:0]     s3_r;
  logic signed [SW-1:0]     s4_r;
  logic signed [2*SW-1:0]   sq_r;
  sqrt_vec_t                sq5_r;
  sqrt_vec_t                sq_chain [SQRT_STEPS+1];

  logic signed [TERM_W-1:0] sinr_d_r [PRE_DLY];
  logic signed [TERM_W-1:0] cosr_d_r [PRE_DLY];
  logic signed [TERM_W-1:0] siny_d_r [PRE_DLY];
  logic signed [TERM_W-1:0] cosy_d_r [PRE_DLY];
  logic [CLAMP_DLY:0]       clamp_d_r;

  // Nothing is taken while the valid pipe is being cleared.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TOTAL-2:0], accept};
    end
  end

  // Stage one: capture the word. Stage two: the nine products.
  always_ff @(posedge clk) begin
    if (accept) begin
      qw_r <= in_quat_w;
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
    end
    wx_r <= qw_r * qx_r;
    yz_r <= qy_r * qz_r;
    xx_r <= qx_r * qx_r;
    yy_r <= qy_r * qy_r;
    wz_r <= qw_r * qz_r;
    xy_r <= qx_r * qy_r;
    zz_r <= qz_r * qz_r;
    wy_r <= qw_r * qy_r;
    zx_r <= qz_r * qx_r;
  end

  // Stage three: sine and cosine terms, and the pitch sine clamped and taken to Q30.
  always_comb begin
    sinr_nxt  = (TERM_W'(wx_r) + TERM_W'(yz_r)) <<< 1;
    cosr_nxt  = ONE_T - ((TERM_W'(xx_r) + TERM_W'(yy_r)) <<< 1);
    siny_nxt  = (TERM_W'(wz_r) + TERM_W'(xy_r)) <<< 1;
    cosy_nxt  = ONE_T - ((TERM_W'(yy_r) + TERM_W'(zz_r)) <<< 1);
    s_raw     = (TERM_W'(wy_r) - TERM_W'(zx_r)) <<< 1;
    s_cl      = s_raw;
    clamp_nxt = 1'b0;
    if (s_raw > ONE_T) begin
      s_cl      = ONE_T;
      clamp_nxt = 1'b1;
    end else if (s_raw < -ONE_T) begin
      s_cl      = -ONE_T;
      clamp_nxt = 1'b1;
    end
    s_sc  = (s_cl >>> RSH_S) <<< LSH_S;
    s_nxt = SW'(s_sc);
  end

  always_ff @(posedge clk) begin
    sinr_r       <= sinr_nxt;
    cosr_r       <= cosr_nxt;
    siny_r       <= siny_nxt;
    cosy_r       <= cosy_nxt;
    s3_r         <= s_nxt;
  end

  // Pitch cosine: square, subtract from one, then the square root cells.
  always_ff @(posedge clk) begin
    sq_r       <= s3_r * s3_r;
    s4_r       <= s3_r;
    sq5_r.rem  <= SQRT_ONE - SQ_W'(sq_r);
    sq5_r.root <= '0;
    sq5_r.s    <= s4_r;
  end

  assign sq_chain[0] = sq5_r;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    q2e_sqrt_cell #(.BIT_POS(SQRT_TOP - 2 * j)) u_sqrt (
      .clk    (clk),
      .cell_i (sq_chain[j]),
      .cell_o (sq_chain[j+1])
    );
  end

  // Delay lines that keep roll, yaw and the clamp flag in step with pitch.
  always_ff @(posedge clk) begin
    sinr_d_r[0] <= sinr_r;
    cosr_d_r[0] <= cosr_r;
    siny_d_r[0] <= siny_r;
    cosy_d_r[0] <= cosy_r;
    for (int i = 1; i < PRE_DLY; i++) begin
      sinr_d_r[i] <= sinr_d_r[i-1];
      cosr_d_r[i] <= cosr_d_r[i-1];
      siny_d_r[i] <= siny_d_r[i-1];
      cosy_d_r[i] <= cosy_d_r[i-1];
    end
    clamp_d_r <= {clamp_d_r[CLAMP_DLY-1:0], clamp_nxt};
  end

  q2e_angle_lane #(
    .IW (TERM_W), .OW (ROLL_W),
    .CORDIC_STEPS (CORDIC_STEPS), .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_roll (
    .clk     (clk),
    .x_i     (cosr_d_r[PRE_DLY-1]),
    .y_i     (sinr_d_r[PRE_DLY-1]),
    .angle_o (out_roll_deg)
  );

  q2e_angle_lane #(
    .IW (SW), .OW (PITCH_W),
    .CORDIC_STEPS (CORDIC_STEPS), .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_pitch (
    .clk     (clk),
    .x_i     ($signed(sq_chain[SQRT_STEPS].root[SW-1:0])),
    .y_i     (sq_chain[SQRT_STEPS].s),
    .angle_o (out_pitch_deg)
  );

  q2e_angle_lane #(
    .IW (TERM_W), .OW (YAW_W),
    .CORDIC_STEPS (CORDIC_STEPS), .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_yaw (
    .clk     (clk),
    .x_i     (cosy_d_r[PRE_DLY-1]),
    .y_i     (siny_d_r[PRE_DLY-1]),
    .angle_o (out_yaw_deg)
  );

  assign out_strobe        = vld_r[TOTAL-1];
  assign out_pitch_clamped = clamp_d_r[CLAMP_DLY];

`include "quaternion_to_euler_angles_core_macros.svh"

  // A taken word must enter the valid pipe on the next edge.
  `Q2E_ASSERT_NEXT(a_accept_enters, accept, vld_r[0], "accepted word missing from valid pipe")
  // The cosine operand of pitch is never negative, so pitch stays within a quarter turn.
  `Q2E_ASSERT_NOW(a_pitch_range, out_strobe, (int'(out_pitch_deg) <= PITCH_LIM && int'(out_pitch_deg) >= -PITCH_LIM), "pitch beyond ninety degrees")
  // A saturated sine means a zero cosine, so pitch must sit at plus or minus ninety degrees.
  `Q2E_ASSERT_NOW(a_clamp_pitch, (out_strobe && out_pitch_clamped), (int'(out_pitch_deg) >= PITCH_MIN || int'(out_pitch_deg) <= -PITCH_MIN), "clamped pitch away from ninety degrees")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the quaternion to roll, pitch and yaw converter.
`default_nettype none
module tb_top;
  import q2e_pkg::*;

  localparam int IN_FRAC   = 14;
  localparam int OUT_FRAC  = 7;
  localparam int STEPS     = 16;
  localparam int LATENCY   = 45 + STEPS;
  localparam int N_RANDOM  = 1550;
  localparam longint CYCLE_LIMIT = 400000;

  // One quaternion word as it enters the block.
  typedef struct packed {
    logic signed [IN_W-1:0] w;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } quat_word_t;

  // One set of Euler angles as it leaves the block.
  typedef struct packed {
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
    logic                      clamped;
  } euler_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_strobe;
  logic signed [ROLL_W-1:0]  out_roll_deg;
  logic signed [PITCH_W-1:0] out_pitch_deg;
  logic signed [YAW_W-1:0]   out_yaw_deg;
  logic out_pitch_clamped;

  quat_word_t  pending_quats[$];
  euler_word_t expected_angles[$];
  int     idle_pct = 0;
  bit     hold_sender = 1'b0;
  bit     stimulus_done = 1'b0;
  int     error_count = 0;
  int     words_sent = 0;
  int     words_checked = 0;
  int     clamp_count = 0;
  longint cycle_count = 0;

  always #4 clk = ~clk;

  quaternion_to_euler_angles_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_quat_w(in_quat_w), .in_quat_x(in_quat_x),
    .in_quat_y(in_quat_y), .in_quat_z(in_quat_z),
    .out_strobe(out_strobe), .out_roll_deg(out_roll_deg),
    .out_pitch_deg(out_pitch_deg), .out_yaw_deg(out_yaw_deg),
    .out_pitch_clamped(out_pitch_clamped)
  );

  // Arithmetic right shift with floor rounding; >>> on a signed longint does just that.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Floor square root by the classic bit-pair method.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Vectoring arctangent in degrees with ANG_FRAC fraction bits. The operands are
  // first brought to a common scale so that the larger magnitude lies in [2^56, 2^57),
  // and the left half plane is folded over by a quarter turn before rotating.
  function automatic longint atan2_degrees(longint sin_term, longint cos_term);
    longint hi, lo, ang, t, dx, dy, xv, yv;
    hi = 64'sd1 <<< 57;
    lo = 64'sd1 <<< 56;
    xv = cos_term;
    yv = sin_term;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    while (magnitude(xv) >= hi || magnitude(yv) >= hi) begin
      xv = floor_shift(xv, 1);
      yv = floor_shift(yv, 1);
    end
    while (magnitude(xv) < lo && magnitude(yv) < lo) begin
      xv = xv * 2;
      yv = yv * 2;
    end
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        ang = 90 * (64'sd1 <<< ANG_FRAC);
      end else begin
        xv = -yv;
        yv = t;
        ang = -90 * (64'sd1 <<< ANG_FRAC);
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_shift(xv, i);
      dy = floor_shift(yv, i);
      if (yv >= 0) begin
        xv = xv + dy;
        yv = yv - dx;
        ang = ang + longint'(ATAN_DEG_TAB[i]);
      end else begin
        xv = xv - dy;
        yv = yv + dx;
        ang = ang - longint'(ATAN_DEG_TAB[i]);
      end
    end
    return ang;
  endfunction

  // Rounds half up to the output fraction and saturates to the field width.
  function automatic longint round_angle(longint ang, int width);
    longint r, top, bot;
    int sh;
    sh = ANG_FRAC - OUT_FRAC;
    r = floor_shift(ang + (64'sd1 <<< (sh - 1)), sh);
    top = (64'sd1 <<< (width - 1)) - 1;
    bot = -(64'sd1 <<< (width - 1));
    if (r > top) r = top;
    if (r < bot) r = bot;
    return r;
  endfunction

  function automatic euler_word_t predict_angles(quat_word_t q);
    longint w, x, y, z, one, sinr, cosr, siny, cosy, s, c;
    euler_word_t e;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    one = 64'sd1 <<< (2 * IN_FRAC);
    sinr = 2 * (w * x + y * z);
    cosr = one - 2 * (x * x + y * y);
    siny = 2 * (w * z + x * y);
    cosy = one - 2 * (y * y + z * z);
    s = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    // A sine of exactly plus or minus one passes untouched and is not flagged.
    if (s > one) begin
      s = one;
      e.clamped = 1'b1;
    end else if (s < -one) begin
      s = -one;
      e.clamped = 1'b1;
    end
    s = s * (64'sd1 <<< (30 - 2 * IN_FRAC));
    c = longint'(floor_sqrt((64'd1 << 60) - longint'(s * s)));
    e.roll  = ROLL_W'(round_angle(atan2_degrees(sinr, cosr), ROLL_W));
    e.pitch = PITCH_W'(round_angle(atan2_degrees(s, c), PITCH_W));
    e.yaw   = YAW_W'(round_angle(atan2_degrees(siny, cosy), YAW_W));
    return e;
  endfunction

  function automatic quat_word_t make_quat(int w, int x, int y, int z);
    quat_word_t q;
    q.w = IN_W'(w);
    q.x = IN_W'(x);
    q.y = IN_W'(y);
    q.z = IN_W'(z);
    return q;
  endfunction

  // A random component: mostly within plus or minus one, sometimes any 16-bit pattern
  // so that every bit of the field is exercised, including the extremes.
  function automatic int random_component();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 32768) - 16384;
    if (pick < 85) return int'($urandom_range(0, 65535)) - 32768;
    if (pick < 92) return (pick & 1) ? 16384 : -16384;
    return int'($urandom_range(0, 15)) - 8;
  endfunction

  // Builds a roughly unit quaternion from random components, so the angles cover
  // the ordinary working range; near the poles the pitch term clamps now and then.
  function automatic quat_word_t random_unit_quat();
    real a, b, cc, d, n;
    quat_word_t q;
    a = real'(int'($urandom_range(0, 2000)) - 1000);
    b = real'(int'($urandom_range(0, 2000)) - 1000);
    cc = real'(int'($urandom_range(0, 2000)) - 1000);
    d = real'(int'($urandom_range(0, 2000)) - 1000);
    n = $sqrt(a * a + b * b + cc * cc + d * d);
    if (n == 0.0) return make_quat(16384, 0, 0, 0);
    q = make_quat(int'(a / n * 16384.0), int'(b / n * 16384.0),
                  int'(cc / n * 16384.0), int'(d / n * 16384.0));
    return q;
  endfunction

  // Driver: a word is offered whenever one is queued and the idling roll allows;
  // start stays high over back-to-back words without being dropped in between.
  always @(posedge clk) begin
    if (rst_n && !(start && busy)) begin
      if (pending_quats.size() != 0 && !hold_sender &&
          int'($urandom_range(0, 99)) >= idle_pct) begin
        quat_word_t q;
        q = pending_quats.pop_front();
        in_quat_w <= q.w;
        in_quat_x <= q.x;
        in_quat_y <= q.y;
        in_quat_z <= q.z;
        start <= 1'b1;
        expected_angles.push_back(predict_angles(q));
        words_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is matched against the oldest expected set.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_strobe) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: result with no word outstanding: roll %0d pitch %0d yaw %0d clamp %0b",
                 $time, out_roll_deg, out_pitch_deg, out_yaw_deg, out_pitch_clamped);
        error_count++;
      end else begin
        euler_word_t e;
        e = expected_angles.pop_front();
        if (out_roll_deg !== e.roll) begin
          $display("%0t: roll expected %0d got %0d", $time, e.roll, out_roll_deg);
          error_count++;
        end
        if (out_pitch_deg !== e.pitch) begin
          $display("%0t: pitch expected %0d got %0d", $time, e.pitch, out_pitch_deg);
          error_count++;
        end
        if (out_yaw_deg !== e.yaw) begin
          $display("%0t: yaw expected %0d got %0d", $time, e.yaw, out_yaw_deg);
          error_count++;
        end
        if (out_pitch_clamped !== e.clamped) begin
          $display("%0t: clamp flag expected %0b got %0b", $time, e.clamped,
                   out_pitch_clamped);
          error_count++;
        end
        if (e.clamped) clamp_count++;
        words_checked++;
      end
    end
  end

  // Watchdog: the slowest correct run is far below this count.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run timed out", $time);
      $display("[quaternion_to_euler_angles_core] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_quats.size() != 0 || start || expected_angles.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int per_phase;
    int phase_idle[4];
    phase_idle = '{0, 82, 0, 38};
    per_phase = N_RANDOM / 4;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: identity, the extremes of each field, the poles with and
    // without clamping, and the degenerate arctangent cases.
    pending_quats.push_back(make_quat(16384, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 0));
    pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
    pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
    pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
    pending_quats.push_back(make_quat(0, 16384, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 16384, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 16384));
    pending_quats.push_back(make_quat(-16384, 0, 0, 0));
    // Sine term just inside plus and minus one, and at plus and minus one half.
    pending_quats.push_back(make_quat(11585, 0, 11585, 0));
    pending_quats.push_back(make_quat(11585, 0, -11585, 0));
    pending_quats.push_back(make_quat(8192, 0, 8192, 0));
    pending_quats.push_back(make_quat(-8192, 0, 8192, 0));
    // Sine term of exactly plus one and minus one: not flagged.
    pending_quats.push_back(make_quat(16384, 0, 8192, 0));
    pending_quats.push_back(make_quat(16384, 0, -8192, 0));
    // Sine term beyond one in both directions: flagged. Then words with a zero sine term.
    pending_quats.push_back(make_quat(16384, 0, 16384, 0));
    pending_quats.push_back(make_quat(16384, 0, -16384, 0));
    pending_quats.push_back(make_quat(0, 16384, 0, 16384));
    pending_quats.push_back(make_quat(0, 16384, 0, -16384));
    pending_quats.push_back(make_quat(11585, 11585, 0, 0));
    pending_quats.push_back(make_quat(11585, -11585, 0, 0));
    pending_quats.push_back(make_quat(11585, 0, 0, -11585));
    pending_quats.push_back(make_quat(1, -1, 1, -1));
    pending_quats.push_back(make_quat(-1, 1, -1, 1));
    wait_drained();

    // Random phases with different amounts of sender idling. Between phases the
    // sender pauses until every outstanding word has been checked.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      hold_sender = 1'b1;
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 3) == 0)
          pending_quats.push_back(make_quat(random_component(), random_component(),
                                            random_component(), random_component()));
        else
          pending_quats.push_back(random_unit_quat());
      end
      @(posedge clk);
      hold_sender = 1'b0;
      // Half way through, hold the sender off until the pipe has fully emptied.
      while (pending_quats.size() > per_phase / 2) @(posedge clk);
      hold_sender = 1'b1;
      while (start || expected_angles.size() != 0) @(posedge clk);
      hold_sender = 1'b0;
      wait_drained();
    end

    stimulus_done = 1'b1;
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d of %0d quaternion words, %0d with a clamped pitch term,",
             words_checked, words_sent, clamp_count);
    $display("over idle-free, sparse and moderate sender phases.");
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("[quaternion_to_euler_angles_core] OK");
    end else begin
      $display("[quaternion_to_euler_angles_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
